[rtl/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types and constants for the LIFO stack with value removal.
// ----------------------------------------------------------------------------
package stk_pkg;

  typedef logic        [1:0]  func_t;
  typedef logic signed [31:0] word_t;
  typedef logic        [6:0]  count_t;

  localparam func_t FUNC_PUSH   = 2'd0;
  localparam func_t FUNC_POP    = 2'd1;
  localparam func_t FUNC_REMOVE = 2'd2;
  localparam func_t FUNC_QUERY  = 2'd3;

  // reported for any entry that is not held
  localparam word_t MISSING_VALUE = 32'sh7FFF_FFFF;

  // position of the middle reported entry, counted from the top
  localparam int THIRD_POS = 3;

endpackage

[rtl/stk_if.sv]
// ----------------------------------------------------------------------------
// stk_in_if / stk_out_if
// Valid/ready channels carrying stack operations and stack results.
// ----------------------------------------------------------------------------
interface stk_in_if;
  logic            valid;
  logic            ready;
  stk_pkg::func_t  func;
  stk_pkg::word_t  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface stk_out_if;
  logic            valid;
  logic            ready;
  stk_pkg::word_t  taken_value;
  logic            underflow;
  logic            overflow;
  stk_pkg::word_t  top_value;
  stk_pkg::word_t  third_value;
  stk_pkg::word_t  bottom_value;
  stk_pkg::count_t entry_count;

  modport source (output valid, output taken_value, output underflow,
                  output overflow, output top_value, output third_value,
                  output bottom_value, output entry_count, input ready);
  modport sink   (input valid, input taken_value, input underflow,
                  input overflow, input top_value, input third_value,
                  input bottom_value, input entry_count, output ready);
endinterface

[rtl/stk_mem.sv]
// ----------------------------------------------------------------------------
// stk_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stk_mem #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  stk_pkg::word_t             wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output stk_pkg::word_t             rd_data
);

  stk_pkg::word_t mem [DEPTH];
  stk_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/stack_with_value_removal.sv]
// ----------------------------------------------------------------------------
// stack_with_value_removal
// Bounded LIFO of signed words with push, pop, remove-by-value and query.
// Each operation returns one word with the popped value, flags and a view
// of the stack (top, third from top, bottom, count).
// ----------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   func, value
//  out_ch    out   valid/ready   taken_value, underflow, overflow,
//                                top_value, third_value, bottom_value,
//                                entry_count
//
//  Each operation fetches top, third and bottom one after another through
//  the single read port of the entry memory; pop first reads the popped
//  entry, and removal first walks every stored entry, writing survivors
//  down in order.
//  Reset: synchronous on rst_n low; the stack is empty, memory not cleared.
//  One operation at a time; in_ch.ready is high only when idle. A result
//  held by out_ch.ready low stalls the finish of the next operation.
// ----------------------------------------------------------------------------
module stack_with_value_removal #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  stk_in_if.sink     in_ch,
  stk_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POPW = 3'd1;
  localparam logic [2:0] S_RM   = 3'd2;
  localparam logic [2:0] S_RPT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // control
  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]    wr_idx_r, wr_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [1:0]       step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  stk_pkg::word_t   value_r, value_nxt;
  stk_pkg::word_t   popped_r, popped_nxt;
  logic             under_r, under_nxt;
  logic             over_r, over_nxt;
  stk_pkg::word_t   top_r, top_nxt;
  stk_pkg::word_t   third_r, third_nxt;
  stk_pkg::word_t   bottom_r, bottom_nxt;
  stk_pkg::word_t   o_popped_r, o_popped_nxt;
  logic             o_under_r, o_under_nxt;
  logic             o_over_r, o_over_nxt;
  stk_pkg::word_t   o_top_r, o_top_nxt;
  stk_pkg::word_t   o_third_r, o_third_nxt;
  stk_pkg::word_t   o_bottom_r, o_bottom_nxt;
  logic [CW-1:0]    o_fill_r, o_fill_nxt;

  // memory port
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  stk_pkg::word_t   mem_wr_data;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  stk_pkg::word_t   mem_rd_data;

  logic [CW-1:0]    fill_m1;
  logic [CW-1:0]    fill_m3;
  logic             rm_issue;

  stk_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign fill_m1  = fill_r - CW'(1);
  assign fill_m3  = fill_r - CW'(stk_pkg::THIRD_POS);
  assign rm_issue = (rd_idx_r < fill_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_nxt      = pend_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    popped_nxt    = popped_r;
    under_nxt     = under_r;
    over_nxt      = over_r;
    top_nxt       = top_r;
    third_nxt     = third_r;
    bottom_nxt    = bottom_r;
    o_popped_nxt  = o_popped_r;
    o_under_nxt   = o_under_r;
    o_over_nxt    = o_over_r;
    o_top_nxt     = o_top_r;
    o_third_nxt   = o_third_r;
    o_bottom_nxt  = o_bottom_r;
    o_fill_nxt    = o_fill_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = fill_r[AW-1:0];
    mem_wr_data   = in_ch.value;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = fill_m1[AW-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          value_nxt  = in_ch.value;
          popped_nxt = stk_pkg::MISSING_VALUE;
          under_nxt  = 1'b0;
          over_nxt   = 1'b0;
          step_nxt   = 2'd0;
          state_nxt  = S_RPT;
          case (in_ch.func)
            stk_pkg::FUNC_PUSH: begin
              if (fill_r == CW'(DEPTH)) begin
                over_nxt = 1'b1;
              end else begin
                mem_wr_en = 1'b1;
                fill_nxt  = fill_r + CW'(1);
              end
            end
            stk_pkg::FUNC_POP: begin
              if (fill_r == '0) begin
                under_nxt = 1'b1;
              end else begin
                mem_rd_en = 1'b1;
                fill_nxt  = fill_m1;
                state_nxt = S_POPW;
              end
            end
            stk_pkg::FUNC_REMOVE: begin
              rd_idx_nxt = '0;
              wr_idx_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_RM;
            end
            default: begin
              state_nxt = S_RPT;
            end
          endcase
        end
      end

      S_POPW: begin
        popped_nxt = mem_rd_data;
        state_nxt  = S_RPT;
      end

      // compaction walk: read slot rd_idx, write survivors down at wr_idx;
      // wr_idx never passes the slot being read, so no overlap hazard
      S_RM: begin
        if (rm_issue) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (pend_r && (mem_rd_data != value_r)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_idx_r[AW-1:0];
          mem_wr_data = mem_rd_data;
          wr_idx_nxt  = wr_idx_r + CW'(1);
        end
        pend_nxt = rm_issue;
        if (!rm_issue && !pend_r) begin
          fill_nxt  = wr_idx_r;
          step_nxt  = 2'd0;
          state_nxt = S_RPT;
        end
      end

      // fetch top, third and bottom, one read per cycle
      S_RPT: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = fill_m1[AW-1:0];
          end
          2'd1: begin
            top_nxt     = (fill_r != '0) ? mem_rd_data : stk_pkg::MISSING_VALUE;
            mem_rd_en   = 1'b1;
            mem_rd_addr = fill_m3[AW-1:0];
          end
          2'd2: begin
            third_nxt   = (fill_r >= CW'(stk_pkg::THIRD_POS)) ?
                          mem_rd_data : stk_pkg::MISSING_VALUE;
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
          end
          default: begin
            bottom_nxt = (fill_r != '0) ? mem_rd_data : stk_pkg::MISSING_VALUE;
            state_nxt  = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_popped_nxt  = popped_r;
          o_under_nxt   = under_r;
          o_over_nxt    = over_r;
          o_top_nxt     = top_r;
          o_third_nxt   = third_r;
          o_bottom_nxt  = bottom_r;
          o_fill_nxt    = fill_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      pend_r      <= 1'b0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      pend_r      <= pend_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    popped_r   <= popped_nxt;
    under_r    <= under_nxt;
    over_r     <= over_nxt;
    top_r      <= top_nxt;
    third_r    <= third_nxt;
    bottom_r   <= bottom_nxt;
    o_popped_r <= o_popped_nxt;
    o_under_r  <= o_under_nxt;
    o_over_r   <= o_over_nxt;
    o_top_r    <= o_top_nxt;
    o_third_r  <= o_third_nxt;
    o_bottom_r <= o_bottom_nxt;
    o_fill_r   <= o_fill_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.taken_value  = o_popped_r;
  assign out_ch.underflow    = o_under_r;
  assign out_ch.overflow     = o_over_r;
  assign out_ch.top_value    = o_top_r;
  assign out_ch.third_value  = o_third_r;
  assign out_ch.bottom_value = o_bottom_r;
  assign out_ch.entry_count  = stk_pkg::count_t'(o_fill_r);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill level beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.func == stk_pkg::FUNC_PUSH &&
     fill_r != CW'(DEPTH)) |=> fill_r == $past(fill_r) + CW'(1))
    else $error("push did not grow the stack");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.func == stk_pkg::FUNC_POP &&
     fill_r != '0) |=> fill_r == $past(fill_r) - CW'(1))
    else $error("pop did not shrink the stack");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM) |-> (wr_idx_r <= rd_idx_r && rd_idx_r <= fill_r))
    else $error("removal write index overtook read index");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_under_r && o_over_r))
    else $error("underflow and overflow together");
`endif

endmodule

[tb/sv/stack_view_checker.sv]
// ----------------------------------------------------------------------------
// stack_view_checker
// Watches the operation and result channels of the stack. Keeps its own
// copy of the stack, works out the view each accepted operation should
// produce, and compares every result word, field by field, in order.
// ----------------------------------------------------------------------------
module stack_view_checker #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  stk_in_if    in_ch,
  stk_out_if   out_ch,
  output int   mismatches,
  output int   outstanding,
  output int   overflows,
  output int   underflows
);
  import stk_pkg::*;

  typedef struct packed {
    word_t  popped;
    logic   underflow;
    logic   overflow;
    word_t  top;
    word_t  third;
    word_t  bottom;
    count_t count;
  } stack_view_t;

  word_t       shadow_mem [DEPTH];
  int          shadow_fill;
  stack_view_t views_due [$];
  stack_view_t want;

  function automatic stack_view_t apply_operation(func_t op, word_t v);
    stack_view_t res;
    int kept;
    res.popped    = MISSING_VALUE;
    res.underflow = 1'b0;
    res.overflow  = 1'b0;
    case (op)
      FUNC_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          shadow_mem[shadow_fill] = v;
          shadow_fill++;
        end
      end
      FUNC_POP: begin
        if (shadow_fill == 0) begin
          res.underflow = 1'b1;
        end else begin
          shadow_fill--;
          res.popped = shadow_mem[shadow_fill];
        end
      end
      FUNC_REMOVE: begin
        // compact in place, survivors keep their order
        kept = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_mem[i] != v) begin
            shadow_mem[kept] = shadow_mem[i];
            kept++;
          end
        end
        shadow_fill = kept;
      end
      default: ;
    endcase
    res.top    = (shadow_fill >= 1) ? shadow_mem[shadow_fill - 1] : MISSING_VALUE;
    res.third  = (shadow_fill >= THIRD_POS) ? shadow_mem[shadow_fill - THIRD_POS]
                                            : MISSING_VALUE;
    res.bottom = (shadow_fill > 0) ? shadow_mem[0] : MISSING_VALUE;
    res.count  = count_t'(shadow_fill);
    return res;
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      views_due.delete();
      mismatches  = 0;
      overflows   = 0;
      underflows  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want = apply_operation(in_ch.func, in_ch.value);
        overflows  += want.overflow;
        underflows += want.underflow;
        views_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (views_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, expected none, got top %0d count %0d",
                   $time, out_ch.top_value, out_ch.entry_count);
        end else begin
          want = views_due.pop_front();
          compare_field("taken_value",  want.popped,    out_ch.taken_value);
          compare_field("underflow",    want.underflow, out_ch.underflow);
          compare_field("overflow",     want.overflow,  out_ch.overflow);
          compare_field("top_value",    want.top,       out_ch.top_value);
          compare_field("third_value",  want.third,     out_ch.third_value);
          compare_field("bottom_value", want.bottom,    out_ch.bottom_value);
          compare_field("entry_count",  want.count,     out_ch.entry_count);
        end
      end
    end
    outstanding = views_due.size();
  end

endmodule

[tb/sv/stack_with_value_removal_tb.sv]
// ----------------------------------------------------------------------------
// stack_with_value_removal_tb
// Drives push, pop, remove-by-value and query words into the stack: a short
// directed run through the corner cases, then random mixes with fill and
// drain bursts under three patterns of sender and receiver idling. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module stack_with_value_removal_tb;
  import stk_pkg::*;

  localparam int DEPTH         = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam int PHASE_WORDS   = 330;
  localparam int BURST_WORDS   = DEPTH + 4;

  logic  clk = 1'b0;
  logic  rst_n;
  int    src_idle_pct;
  int    snk_idle_pct;
  int    cycle_count;
  int    words_sent;
  int    sent_by_func [4];
  int    mismatches;
  int    outstanding;
  int    overflows;
  int    underflows;
  word_t value_pool [8];

  stk_in_if  in_ch ();
  stk_out_if out_ch ();

  stack_with_value_removal #(.DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stack_view_checker #(.DEPTH(DEPTH)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .overflows   (overflows),
    .underflows  (underflows)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // holds the word until accepted; valid stays high into the next word
  task automatic send_word(input func_t op, input word_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= op;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    sent_by_func[op]++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // pool values repeat often so removals find duplicates
  function automatic word_t pick_value();
    if ($urandom_range(99) < 60)
      return value_pool[$urandom_range(7)];
    return word_t'($urandom);
  endfunction

  task automatic run_phase(input int src_pct, input int snk_pct);
    int done;
    int pick;
    int r;
    src_idle_pct  = src_pct;
    snk_idle_pct  = snk_pct;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = MISSING_VALUE;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int i = 4; i < 8; i++) value_pool[i] = word_t'($urandom);
    done = 0;
    while (done < PHASE_WORDS) begin
      pick = $urandom_range(15);
      if (pick < 2) begin
        // fill past the top so the last pushes are dropped
        repeat (BURST_WORDS) send_word(FUNC_PUSH, pick_value());
        done += BURST_WORDS;
      end else if (pick < 4) begin
        repeat (BURST_WORDS) send_word(FUNC_POP, word_t'($urandom));
        done += BURST_WORDS;
      end else if (pick == 4) begin
        for (int i = 0; i < 8; i++) send_word(FUNC_REMOVE, value_pool[i]);
        done += 8;
      end else begin
        repeat (12) begin
          r = $urandom_range(99);
          if (r < 40)
            send_word(FUNC_PUSH, pick_value());
          else if (r < 62)
            send_word(FUNC_POP, word_t'($urandom));
          else if (r < 77)
            send_word(FUNC_REMOVE, ($urandom_range(99) < 80) ? value_pool[$urandom_range(7)]
                                                              : word_t'($urandom));
          else
            send_word(FUNC_QUERY, word_t'($urandom));
        end
        done += 12;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_QUERY;
    in_ch.value  = '0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    words_sent   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack corners
    send_word(FUNC_QUERY,  32'sd0);
    send_word(FUNC_POP,    32'sd0);
    send_word(FUNC_REMOVE, 32'sd5);
    // extremes, including one equal to the missing-entry marker
    send_word(FUNC_PUSH,   32'sh8000_0000);
    send_word(FUNC_PUSH,   MISSING_VALUE);
    send_word(FUNC_PUSH,   32'sd0);
    send_word(FUNC_PUSH,   -32'sd1);
    send_word(FUNC_PUSH,   MISSING_VALUE);
    send_word(FUNC_QUERY,  32'sh1234_5678);
    send_word(FUNC_REMOVE, 32'sd42);
    send_word(FUNC_REMOVE, MISSING_VALUE);
    send_word(FUNC_PUSH,   32'sd7);
    send_word(FUNC_PUSH,   32'sd7);
    send_word(FUNC_POP,    32'sd0);
    send_word(FUNC_REMOVE, 32'sd7);
    repeat (4) send_word(FUNC_POP, -32'sd1);
    send_word(FUNC_PUSH,   32'sh5555_5555);
    send_word(FUNC_PUSH,   32'shAAAA_AAAA);
    // bottom entry goes, top survives
    send_word(FUNC_REMOVE, 32'sh5555_5555);
    pause_until_drained();

    run_phase(24, 61);
    run_phase(61, 24);
    pause_until_drained();
    run_phase(0, 0);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words sent: %0d push, %0d pop, %0d remove, %0d query",
             words_sent, sent_by_func[FUNC_PUSH], sent_by_func[FUNC_POP],
             sent_by_func[FUNC_REMOVE], sent_by_func[FUNC_QUERY]);
    $display("pushes onto a full stack: %0d, pops from an empty one: %0d",
             overflows, underflows);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/stk_pkg.sv
rtl/stk_if.sv
rtl/stk_mem.sv
rtl/stack_with_value_removal.sv
tb/sv/stack_view_checker.sv
tb/sv/stack_with_value_removal_tb.sv
